FILE: rtl/dbpq_pkg.sv
// shared types and codes for the degree bucket priority queue
package dbpq_pkg;

   // request operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_CHANGE = 2'd2;
   localparam logic [1:0] OP_POP    = 2'd3;

   // response status codes
   localparam logic [1:0] STAT_DONE       = 2'd0;
   localparam logic [1:0] STAT_EMPTY      = 2'd1;
   localparam logic [1:0] STAT_QUEUED     = 2'd2;
   localparam logic [1:0] STAT_NOT_QUEUED = 2'd3;

   // reset value of the degree limit register
   localparam logic [7:0] DEGREE_LIMIT_RESET = 8'd254;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_NODE,
      ST_UNL_RD,
      ST_UNL_WR,
      ST_LINK_RD,
      ST_LINK_WR,
      ST_LINK_FIX,
      ST_SCAN,
      ST_POP_HEAD,
      ST_POP_NODE,
      ST_FIN
   } state_type;

endpackage

FILE: rtl/degree_bucket_priority_queue.sv
// bucket priority queue of node indices keyed by degree, linked lists in memories
//
//  port group | dir | handshake            | payload
//  req_       | in  | req_valid/req_ready  | operation, node_index, node_degree
//  rsp_       | out | rsp_valid/rsp_ready  | status, result_node, result_bucket
//  csr_       | in  | csr_write_enable     | degree limit (8 bits)
//
//  a pop scans the occupancy bits one 16-bucket group at a time, up to
//  BUCKET_COUNT/16 groups; the memories have registered reads.
//  after reset a clearing pass over all NODE_COUNT nodes wipes the queued flags;
//  no request is taken until it ends.
//  a finished response sits in the output register while the next request is
//  accepted; the sequencer waits only if that register is still full.
//  NODE_COUNT and BUCKET_COUNT are powers of two.
module degree_bucket_priority_queue
   import dbpq_pkg::*;
#(
   parameter int NODE_COUNT   = 1024,
   parameter int BUCKET_COUNT = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [9:0] req_node_index,
   input  logic [9:0] req_node_degree,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [9:0] rsp_result_node,
   output logic [7:0] rsp_result_bucket,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   localparam int NW   = $clog2(NODE_COUNT);
   localparam int BW   = $clog2(BUCKET_COUNT);
   localparam int GRP  = (BUCKET_COUNT < 16) ? BUCKET_COUNT : 16;
   localparam int LW   = $clog2(GRP);
   localparam int NGRP = BUCKET_COUNT / GRP;
   localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam logic [NW:0] LINK_NONE = {1'b1, {NW{1'b0}}};

   // memories
   logic [NW:0]   head_mem   [BUCKET_COUNT];
   logic [NW:0]   next_mem   [NODE_COUNT];
   logic [NW-1:0] prev_mem   [NODE_COUNT];
   logic [BW-1:0] bucket_mem [NODE_COUNT];
   logic          queued_mem [NODE_COUNT];

   logic [NW:0]   head_q;
   logic [NW:0]   next_q;
   logic [BW-1:0] bucket_q;
   logic          queued_q;

   logic          head_we, next_we, prev_we, bucket_we, queued_we;
   logic [BW-1:0] head_wa, head_ra;
   logic [NW:0]   head_wd, next_wd;
   logic [NW-1:0] next_wa, prev_wa, prev_wd, node_wa, node_ra;
   logic [BW-1:0] bucket_wd;
   logic          queued_wd;
   logic [NW-1:0] prev_q;

   // registers
   state_type         state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [9:0]        deg_ff, deg_in;
   logic [BW-1:0]     b_ff, b_in;
   logic [BW-1:0]     tb_ff, tb_in;
   logic [NW:0]       nx_ff, nx_in;
   logic [NW-1:0]     pv_ff, pv_in;
   logic [NW:0]       h_ff, h_in;
   logic [GW-1:0]     scan_ff, scan_in;
   logic [NW-1:0]     clr_ff, clr_in;
   logic [BUCKET_COUNT-1:0] occ_ff, occ_in;
   logic [7:0]        limit_ff;
   logic [1:0]        res_status_ff, res_status_in;
   logic [NW-1:0]     res_node_ff, res_node_in;
   logic [BW-1:0]     res_bucket_ff, res_bucket_in;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [9:0]        rsp_node_ff;
   logic [7:0]        rsp_bucket_ff;
   logic              rsp_load;

   // head memory
   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
      head_q <= head_mem[head_ra];
   end

   // per-node link memories, all read at the same node address
   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      next_q <= next_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      prev_q <= prev_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (bucket_we) bucket_mem[node_wa] <= bucket_wd;
      bucket_q <= bucket_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (queued_we) queued_mem[node_wa] <= queued_wd;
      queued_q <= queued_mem[node_ra];
   end

   // effective limit, keeping the overflow bucket in range
   logic [BW-1:0] lim;
   always_comb begin
      if (32'(limit_ff) > BUCKET_COUNT - 2) lim = BW'(BUCKET_COUNT - 2);
      else lim = BW'(limit_ff);
   end

   // bucket for the latched degree
   logic [BW-1:0] deg_bucket;
   assign deg_bucket = (32'(deg_ff) > 32'(lim)) ? BW'(32'(lim) + 1) : BW'(deg_ff);

   // first occupied bucket at or below the limit in the current group
   logic          scan_hit;
   logic [BW-1:0] scan_idx;
   logic [BW-1:0] grp_end;
   always_comb begin
      logic [BW-1:0] cand;
      scan_hit = 1'b0;
      scan_idx = '0;
      for (int i = GRP - 1; i >= 0; i--) begin
         cand = BW'({scan_ff, LW'(i)});
         if (occ_ff[cand] && cand <= lim) begin
            scan_hit = 1'b1;
            scan_idx = cand;
         end
      end
   end
   assign grp_end = BW'({scan_ff, {LW{1'b1}}});

   // unlink decisions
   logic is_head;
   assign is_head = (head_q == {1'b0, n_ff});

   // sequencer next state and memory controls
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      n_in          = n_ff;
      deg_in        = deg_ff;
      b_in          = b_ff;
      tb_in         = tb_ff;
      nx_in         = nx_ff;
      pv_in         = pv_ff;
      h_in          = h_ff;
      scan_in       = scan_ff;
      clr_in        = clr_ff;
      occ_in        = occ_ff;
      res_status_in = res_status_ff;
      res_node_in   = res_node_ff;
      res_bucket_in = res_bucket_ff;
      req_ready     = 1'b0;
      rsp_load      = 1'b0;
      head_we   = 1'b0; head_wa = b_ff; head_wd = nx_ff; head_ra = b_ff;
      next_we   = 1'b0; next_wa = pv_ff; next_wd = nx_ff;
      prev_we   = 1'b0; prev_wa = nx_ff[NW-1:0]; prev_wd = pv_ff;
      bucket_we = 1'b0; bucket_wd = tb_ff;
      queued_we = 1'b0; queued_wd = 1'b0;
      node_wa   = n_ff;
      node_ra   = n_ff;
      case (state_ff)
         // wipe queued flags after reset
         ST_CLEAR: begin
            queued_we = 1'b1;
            node_wa   = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == NW'(NODE_COUNT - 1)) state_in = ST_IDLE;
         end
         // take a transaction and start the node read
         ST_IDLE: begin
            req_ready = 1'b1;
            node_ra   = NW'(req_node_index);
            if (req_valid) begin
               op_in   = req_operation;
               n_in    = NW'(req_node_index);
               deg_in  = req_node_degree;
               scan_in = '0;
               state_in = (req_operation == OP_POP) ? ST_SCAN : ST_NODE;
            end
         end
         // node data is back
         ST_NODE: begin
            b_in  = bucket_q;
            nx_in = next_q;
            pv_in = prev_q;
            res_node_in = n_ff;
            if (op_ff == OP_INSERT) begin
               if (queued_q) begin
                  res_status_in = STAT_QUEUED;
                  res_bucket_in = bucket_q;
                  state_in = ST_FIN;
               end else begin
                  tb_in = deg_bucket;
                  state_in = ST_LINK_RD;
               end
            end else if (!queued_q) begin
               res_status_in = STAT_NOT_QUEUED;
               res_bucket_in = '0;
               state_in = ST_FIN;
            end else begin
               state_in = ST_UNL_RD;
            end
         end
         ST_UNL_RD: begin
            head_ra  = b_ff;
            state_in = ST_UNL_WR;
         end
         // unlink the node from its bucket
         ST_UNL_WR: begin
            queued_we = 1'b1;
            queued_wd = 1'b0;
            if (is_head) begin
               head_we = 1'b1;
               head_wa = b_ff;
               head_wd = nx_ff;
               if (nx_ff[NW]) occ_in[b_ff] = 1'b0;
            end else begin
               next_we = 1'b1;
            end
            prev_we = !nx_ff[NW];
            prev_wd = is_head ? nx_ff[NW-1:0] : pv_ff;
            if (op_ff == OP_CHANGE) begin
               tb_in = (32'(deg_ff) == 32'(b_ff)) ? b_ff : deg_bucket;
               state_in = ST_LINK_RD;
            end else begin
               res_status_in = STAT_DONE;
               res_node_in   = n_ff;
               res_bucket_in = b_ff;
               state_in = ST_FIN;
            end
         end
         ST_LINK_RD: begin
            head_ra  = tb_ff;
            state_in = ST_LINK_WR;
         end
         // link the node at the head of its target bucket
         ST_LINK_WR: begin
            h_in      = occ_ff[tb_ff] ? head_q : LINK_NONE;
            head_we   = 1'b1;
            head_wa   = tb_ff;
            head_wd   = {1'b0, n_ff};
            next_we   = 1'b1;
            next_wa   = n_ff;
            next_wd   = occ_ff[tb_ff] ? head_q : LINK_NONE;
            prev_we   = 1'b1;
            prev_wa   = n_ff;
            prev_wd   = n_ff;
            bucket_we = 1'b1;
            bucket_wd = tb_ff;
            queued_we = 1'b1;
            queued_wd = 1'b1;
            occ_in[tb_ff] = 1'b1;
            res_status_in = STAT_DONE;
            res_node_in   = n_ff;
            res_bucket_in = tb_ff;
            state_in = occ_ff[tb_ff] ? ST_LINK_FIX : ST_FIN;
         end
         // old head points back at the new one
         ST_LINK_FIX: begin
            prev_we  = 1'b1;
            prev_wa  = h_ff[NW-1:0];
            prev_wd  = n_ff;
            state_in = ST_FIN;
         end
         // search the occupancy bits one group a cycle
         ST_SCAN: begin
            if (scan_hit) begin
               b_in = scan_idx;
               state_in = ST_POP_HEAD;
            end else if (scan_ff == GW'(NGRP - 1) || grp_end >= lim) begin
               res_status_in = STAT_EMPTY;
               res_node_in   = '0;
               res_bucket_in = '0;
               state_in = ST_FIN;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_POP_HEAD: begin
            head_ra  = b_ff;
            state_in = ST_POP_NODE;
         end
         ST_POP_NODE: begin
            n_in     = head_q[NW-1:0];
            node_ra  = head_q[NW-1:0];
            state_in = ST_NODE;
         end
         // hand the result to the output register
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         occ_ff       <= '0;
         limit_ff     <= DEGREE_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         occ_ff   <= occ_in;
         if (csr_write_enable) limit_ff <= csr_write_data;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      n_ff          <= n_in;
      deg_ff        <= deg_in;
      b_ff          <= b_in;
      tb_ff         <= tb_in;
      nx_ff         <= nx_in;
      pv_ff         <= pv_in;
      h_ff          <= h_in;
      scan_ff       <= scan_in;
      res_status_ff <= res_status_in;
      res_node_ff   <= res_node_in;
      res_bucket_ff <= res_bucket_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_node_ff   <= 10'(res_node_ff);
         rsp_bucket_ff <= 8'(res_bucket_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_node   = rsp_node_ff;
   assign rsp_result_bucket = rsp_bucket_ff;

   // no transaction is taken during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("request accepted during clearing pass");

   // a linked bucket is marked occupied
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LINK_WR |=> occ_ff[tb_ff])
      else $error("bucket not occupied after link");

   // a pending response is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && !rsp_ready) |=> state_ff == ST_FIN)
      else $error("response register overwritten");

endmodule
